>>> hdl/lzss_pkg.sv
// shared types and constants for the lzss stream decompressor
// word formats on both channels and the command word between front and back
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lzss_pkg;

    // result status codes
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_DIST  = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    // token layout: 12-bit distance over 4-bit length code
    localparam int         DIST_BITS = 12;
    localparam int         LEN_BITS  = 4;
    localparam int         COUNT_BITS = 5;
    localparam logic [COUNT_BITS-1:0] LEN_BIAS = 5'd3;

    localparam int CMD_FIFO_DEPTH = 4;
    localparam int OUT_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        blob_last;
        logic [23:0] blob_size;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       blob_done;
        logic [1:0] status;
    } out_word_t;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_COPY,
        CMD_STAT
    } cmd_kind_t;

    // one unit of work for the back end
    typedef struct packed {
        cmd_kind_t             kind;
        logic [7:0]            data;
        logic [DIST_BITS-1:0]  back_dist;
        logic [COUNT_BITS-1:0] count;
        logic                  done;
        logic [1:0]            status;
    } cmd_t;

endpackage

`default_nettype wire

>>> hdl/lzss_fifo.sv
// small synchronous queue of packed words, first word shown on the read side
// generic in word type and depth (power of two, at least two)
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module lzss_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    localparam int PW = $clog2(DEPTH);

    T               entries_reg [DEPTH];
    logic [PW:0]    wptr_reg;
    logic [PW:0]    rptr_reg;
    logic           do_wr;
    logic           do_rd;

    assign empty = (wptr_reg == rptr_reg);
    assign full  = (wptr_reg[PW] != rptr_reg[PW]) &&
                   (wptr_reg[PW-1:0] == rptr_reg[PW-1:0]);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = entries_reg[rptr_reg[PW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + (PW+1)'(1);
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wptr_reg[PW-1:0]] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lzss_front.sv
// front end: parses flag bytes and tokens, tracks blob progress and errors
// and issues literal, copy and status commands; depends on lzss_pkg
`timescale 1ns / 1ps
`default_nettype none

module lzss_front #(
    parameter int SIZE_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lzss_pkg::in_word_t in_word,
    input  logic             cmd_full,
    output logic             cmd_push,
    output lzss_pkg::cmd_t   cmd
);

    import lzss_pkg::*;

    typedef enum logic [1:0] {
        PP_FLAG,
        PP_UNIT,
        PP_TLOW
    } parse_phase_t;

    typedef enum logic [1:0] {
        BP_IDLE,
        BP_RUN,
        BP_DONE
    } blob_phase_t;

    parse_phase_t           parse_phase_reg, parse_phase_next;
    blob_phase_t            blob_phase_reg, blob_phase_next;
    logic [SIZE_BITS-1:0]   produced_reg, produced_next;
    logic [SIZE_BITS-1:0]   target_reg, target_next;
    logic [7:0]             flag_bits_reg, flag_bits_next;
    logic [3:0]             bits_left_reg, bits_left_next;
    logic [7:0]             token_high_reg, token_high_next;

    logic                   accept;
    logic                   start;
    logic                   last;
    logic [7:0]             b;
    logic [31:0]            size_ext;
    parse_phase_t           pp_cur;
    logic [SIZE_BITS-1:0]   prod_cur;
    logic [SIZE_BITS-1:0]   tgt_cur;
    logic [SIZE_BITS-1:0]   remain;
    logic [7:0]             flags_cur;
    logic [3:0]             bits_cur;
    logic [3:0]             bits_dec;
    logic [15:0]            token;
    logic [DIST_BITS-1:0]   back_dist;
    logic [COUNT_BITS-1:0]  len;
    logic [COUNT_BITS-1:0]  count;
    logic                   unit_done;
    logic                   finish;
    logic [1:0]             fin_status;

    assign accept   = push && !cmd_full;
    assign last     = in_word.blob_last;
    assign b        = in_word.in_byte;
    assign size_ext = 32'(in_word.blob_size);

    // a new blob starts from cleared parse state
    assign start     = (blob_phase_reg == BP_IDLE);
    assign pp_cur    = start ? PP_FLAG : parse_phase_reg;
    assign prod_cur  = start ? '0 : produced_reg;
    assign tgt_cur   = start ? size_ext[SIZE_BITS-1:0] : target_reg;
    assign flags_cur = start ? 8'd0 : flag_bits_reg;
    assign bits_cur  = start ? 4'd0 : bits_left_reg;
    assign bits_dec  = (bits_cur != 4'd0) ? bits_cur - 4'd1 : 4'd0;

    assign token     = {(start ? 8'd0 : token_high_reg), b};
    assign back_dist = token[15:LEN_BITS];
    assign len       = COUNT_BITS'(token[LEN_BITS-1:0]) + LEN_BIAS;
    assign remain    = tgt_cur - prod_cur;
    assign count     = (remain < SIZE_BITS'(len)) ? remain[COUNT_BITS-1:0] : len;

    always_comb
    begin
        parse_phase_next = parse_phase_reg;
        blob_phase_next  = blob_phase_reg;
        produced_next    = produced_reg;
        target_next      = target_reg;
        flag_bits_next   = flag_bits_reg;
        bits_left_next   = bits_left_reg;
        token_high_next  = token_high_reg;
        cmd_push         = 1'b0;
        cmd              = '0;
        cmd.kind         = CMD_STAT;
        cmd.status       = ST_RUN;
        unit_done        = 1'b0;
        finish           = 1'b0;
        fin_status       = ST_RUN;

        if (accept)
        begin
            if (blob_phase_reg == BP_DONE)
            begin
                // tail of a finished blob is dropped
                if (last)
                begin
                    blob_phase_next = BP_IDLE;
                end
            end
            else
            begin
                parse_phase_next = pp_cur;
                produced_next    = prod_cur;
                target_next      = tgt_cur;
                flag_bits_next   = flags_cur;
                bits_left_next   = bits_cur;
                token_high_next  = start ? 8'd0 : token_high_reg;
                blob_phase_next  = BP_RUN;

                if (start && (tgt_cur == '0))
                begin
                    finish     = 1'b1;
                    fin_status = ST_OK;
                end
                else
                begin
                    unique case (pp_cur)
                        PP_FLAG:
                        begin
                            flag_bits_next   = b;
                            bits_left_next   = 4'd8;
                            parse_phase_next = PP_UNIT;
                        end
                        PP_UNIT:
                        begin
                            if (flags_cur[0])
                            begin
                                cmd_push      = 1'b1;
                                cmd.kind      = CMD_LIT;
                                cmd.data      = b;
                                produced_next = prod_cur + SIZE_BITS'(1);
                                unit_done     = 1'b1;
                            end
                            else
                            begin
                                token_high_next  = b;
                                parse_phase_next = PP_TLOW;
                            end
                        end
                        PP_TLOW:
                        begin
                            if ((back_dist == '0) || (SIZE_BITS'(back_dist) > prod_cur))
                            begin
                                finish     = 1'b1;
                                fin_status = ST_DIST;
                            end
                            else
                            begin
                                cmd_push      = 1'b1;
                                cmd.kind      = CMD_COPY;
                                cmd.back_dist = back_dist;
                                cmd.count     = count;
                                produced_next = prod_cur + SIZE_BITS'(count);
                                unit_done     = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (unit_done)
                    begin
                        flag_bits_next   = flags_cur >> 1;
                        bits_left_next   = bits_dec;
                        parse_phase_next = (bits_dec == 4'd0) ? PP_FLAG : PP_UNIT;
                        if (produced_next >= tgt_cur)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_OK;
                        end
                        else if (last)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_SHORT;
                        end
                    end
                    else if (!finish && last)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_SHORT;
                    end
                end

                // end of blob rides on the byte command, or goes alone
                if (finish)
                begin
                    cmd_push        = 1'b1;
                    cmd.done        = 1'b1;
                    cmd.status      = fin_status;
                    blob_phase_next = last ? BP_IDLE : BP_DONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase_reg <= PP_FLAG;
            blob_phase_reg  <= BP_IDLE;
            produced_reg    <= '0;
            target_reg      <= '0;
            flag_bits_reg   <= '0;
            bits_left_reg   <= '0;
            token_high_reg  <= '0;
        end
        else
        begin
            parse_phase_reg <= parse_phase_next;
            blob_phase_reg  <= blob_phase_next;
            produced_reg    <= produced_next;
            target_reg      <= target_next;
            flag_bits_reg   <= flag_bits_next;
            bits_left_reg   <= bits_left_next;
            token_high_reg  <= token_high_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lzss_back.sv
// back end: carries out commands against the history window and emits words
// holds the history memory; depends on lzss_pkg
`timescale 1ns / 1ps
`default_nettype none

module lzss_back #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_empty,
    input  lzss_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    input  logic                out_full,
    output logic                out_push,
    output lzss_pkg::out_word_t out_word
);

    import lzss_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_WRITE
    } back_state_t;

    back_state_t            state_reg, state_next;
    logic [AW-1:0]          wptr_reg, wptr_next;
    logic [DIST_BITS-1:0]   dist_reg, dist_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   done_reg, done_next;
    logic [1:0]             status_reg, status_next;

    logic [7:0]             hist_mem [WINDOW_DEPTH];
    logic [7:0]             rd_data_reg;
    logic                   hist_we;
    logic [AW-1:0]          hist_waddr;
    logic [AW-1:0]          hist_raddr;
    logic [7:0]             hist_wdata;
    logic                   copy_last;

    assign hist_waddr = wptr_reg;
    assign hist_raddr = wptr_reg - AW'(dist_reg);
    assign copy_last  = (count_reg == COUNT_BITS'(1));

    always_comb
    begin
        state_next  = state_reg;
        wptr_next   = wptr_reg;
        dist_next   = dist_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        status_next = status_reg;
        cmd_pop     = 1'b0;
        out_push    = 1'b0;
        out_word    = '0;
        hist_we     = 1'b0;
        hist_wdata  = cmd.data;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty && !out_full)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_LIT:
                        begin
                            hist_we             = 1'b1;
                            out_push            = 1'b1;
                            out_word.out_byte   = cmd.data;
                            out_word.byte_valid = 1'b1;
                            out_word.blob_done  = cmd.done;
                            out_word.status     = cmd.status;
                            wptr_next           = cmd.done ? '0 : wptr_reg + AW'(1);
                        end
                        CMD_COPY:
                        begin
                            dist_next   = cmd.back_dist;
                            count_next  = cmd.count;
                            done_next   = cmd.done;
                            status_next = cmd.status;
                            state_next  = B_READ;
                        end
                        CMD_STAT:
                        begin
                            out_push           = 1'b1;
                            out_word.blob_done = 1'b1;
                            out_word.status    = cmd.status;
                            wptr_next          = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_READ:
            begin
                // room is reserved here for the word pushed in the next cycle
                if (!out_full)
                begin
                    state_next = B_WRITE;
                end
            end
            B_WRITE:
            begin
                hist_we             = 1'b1;
                hist_wdata          = rd_data_reg;
                out_push            = 1'b1;
                out_word.out_byte   = rd_data_reg;
                out_word.byte_valid = 1'b1;
                out_word.blob_done  = done_reg && copy_last;
                out_word.status     = copy_last ? status_reg : ST_RUN;
                count_next          = count_reg - COUNT_BITS'(1);
                if (copy_last)
                begin
                    state_next = B_IDLE;
                    wptr_next  = done_reg ? '0 : wptr_reg + AW'(1);
                end
                else
                begin
                    state_next = B_READ;
                    wptr_next  = wptr_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            wptr_reg   <= '0;
            dist_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_RUN;
        end
        else
        begin
            state_reg  <= state_next;
            wptr_reg   <= wptr_next;
            dist_reg   <= dist_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    // history window, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        rd_data_reg <= hist_mem[hist_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/lzss_stream_decompressor_top.sv
// lzss stream decompressor, 4k-window style: one compressed byte in per word,
// one decompressed byte (or a bare end-of-blob status) out per word.
//
// input channel: push/full with in_word; a word is taken when push && !full.
// the first word of a blob samples blob_size; blob_last closes the blob.
// output channel: empty/pop with out_word; the oldest result is shown while
// empty is low and leaves when pop && !empty.
// the front parser takes one word per cycle while full is low, and hands
// literal, copy and status commands to a 4-entry queue; the back end drains
// it into the history window and a 4-entry result queue.
// at the back a literal or status is handled in a single step; a copy reads
// each byte through the history memory's registered read and then writes it,
// and no new command is taken until the copy is finished.
// a literal accepted at the input passes through the command queue and the
// back end into the result queue before it can be popped.
// reset clears both queues and all parse state; the history window is not
// cleared. a stalled consumer fills the result queue, then the command
// queue, and then full holds off the producer; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module lzss_stream_decompressor_top #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int SIZE_BITS    = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lzss_pkg::in_word_t  in_word,
    output logic                empty,
    input  logic                pop,
    output lzss_pkg::out_word_t out_word
);

    import lzss_pkg::*;

    logic      cmd_push;
    logic      cmd_full;
    logic      cmd_pop;
    logic      cmd_empty;
    cmd_t      cmd_in;
    cmd_t      cmd_head;
    logic      res_push;
    logic      res_full;
    out_word_t res_word;

    assign full = cmd_full;

    lzss_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_word  (in_word),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    lzss_fifo #(
        .T     (cmd_t),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    lzss_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .out_full  (res_full),
        .out_push  (res_push),
        .out_word  (res_word)
    );

    lzss_fifo #(
        .T     (out_word_t),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_word),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_word),
        .empty   (empty)
    );

endmodule

`default_nettype wire

>>> hdl/lzss_checker.sv
// port-level checks on the result channel of the decompressor top level
// bound to lzss_stream_decompressor_top; depends on lzss_pkg
`timescale 1ns / 1ps
`default_nettype none

module lzss_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input lzss_pkg::out_word_t out_word
);

    import lzss_pkg::*;

    // a word with no byte only ever closes a blob
    a_bare_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_word.byte_valid) |-> out_word.blob_done)
        else $error("result without byte does not close its blob");

    // final status appears exactly on the closing word
    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_word.blob_done) |-> (out_word.status != ST_RUN))
        else $error("closing word carries running status");

    a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_word.blob_done) |-> (out_word.status == ST_RUN))
        else $error("final status on a word that does not close the blob");

    a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_word.byte_valid) |-> (out_word.out_byte == 8'd0))
        else $error("byte field not zero on a word without byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_word)))
        else $error("waiting result changed or vanished");

endmodule

bind lzss_stream_decompressor_top lzss_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
);

`default_nettype wire
